@@ hdl/fbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator package
// Shared widths, codes, defaults and controller/datapath types.
// ----------------------------------------------------------------------------
package fbsa_pkg;

   localparam int BLOCK_COUNT_DEF = 1024;
   localparam int BLOCK_BYTES_DEF = 4096;

   localparam int CMD_W      = 2;
   localparam int SIZE_W     = 32;
   localparam int OFFSET_W   = 22;
   localparam int BYTES_W    = 23;
   localparam int RESERVED_W = 11;
   localparam int STATUS_W   = 2;

   localparam logic [RESERVED_W-1:0] RESERVED_RESET = RESERVED_W'(3);

   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INFO  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic capture;
      logic init_clear;
      logic init_write;
      logic init_finish;
      logic commit;
   } fbsa_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] req_command;
      logic             init_last;
      logic             out_free;
   } fbsa_stat_type;

endpackage

@@ hdl/fbsa_if.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbsa_req_if;
   import fbsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [SIZE_W-1:0]   request_size;
   logic [OFFSET_W-1:0] freed_offset;

   modport source (output valid, command, request_size, freed_offset, input ready);
   modport sink (input valid, command, request_size, freed_offset, output ready);
endinterface

interface fbsa_rsp_if;
   import fbsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OFFSET_W-1:0] block_offset;
   logic [BYTES_W-1:0]  free_bytes;
   logic [BYTES_W-1:0]  total_bytes;

   modport source (output valid, status, block_offset, free_bytes, total_bytes,
                   input ready);
   modport sink (input valid, status, block_offset, free_bytes, total_bytes,
                 output ready);
endinterface

@@ hdl/fbsa_ram.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbsa_datapath.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator datapath
// Request capture, stack pointer, free stack memory, init walk and result word.
// ----------------------------------------------------------------------------
module fbsa_datapath #(
   parameter int BLOCK_COUNT_P = fbsa_pkg::BLOCK_COUNT_DEF,
   parameter int BLOCK_BYTES   = fbsa_pkg::BLOCK_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbsa_pkg::fbsa_cmd_type              cmd,
   output fbsa_pkg::fbsa_stat_type             stat,
   input  logic [fbsa_pkg::CMD_W-1:0]          req_command,
   input  logic [fbsa_pkg::SIZE_W-1:0]         req_request_size,
   input  logic [fbsa_pkg::OFFSET_W-1:0]       req_freed_offset,
   input  logic [fbsa_pkg::RESERVED_W-1:0]     reserved_blocks,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fbsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbsa_pkg::OFFSET_W-1:0]       rsp_block_offset,
   output logic [fbsa_pkg::BYTES_W-1:0]        rsp_free_bytes,
   output logic [fbsa_pkg::BYTES_W-1:0]        rsp_total_bytes
);
   import fbsa_pkg::*;

   localparam int ADDR_W = $clog2(BLOCK_COUNT_P);
   localparam int TOP_W  = $clog2(BLOCK_COUNT_P + 1);
   localparam logic [TOP_W-1:0]   TOP_FULL = TOP_W'(BLOCK_COUNT_P);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BLOCK_COUNT_P - 1);
   localparam logic [63:0]        TOTAL_WIDE = 64'(BLOCK_COUNT_P) * 64'(BLOCK_BYTES);
   localparam logic [BYTES_W-1:0] TOTAL_BYTES = TOTAL_WIDE[BYTES_W-1:0];
   localparam logic [OFFSET_W-1:0] STEP_BYTES = OFFSET_W'(BLOCK_BYTES);
   localparam logic [SIZE_W-1:0]  MAX_SIZE = SIZE_W'(BLOCK_BYTES);

   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [OFFSET_W-1:0] freed_ff, freed_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [OFFSET_W-1:0] acc_ff, acc_in;
   logic [BYTES_W-1:0]  avail_bytes_ff, avail_bytes_in;
   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [BYTES_W-1:0]  free_ff, free_in;
   logic [BYTES_W-1:0]  total_ff, total_in;

   logic [TOP_W-1:0]    top_dec;
   logic                refuse;
   logic                underflow;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [OFFSET_W-1:0] ram_wdata;
   logic [OFFSET_W-1:0] ram_rdata;
   logic [TOP_W-1:0]    top_init;

   fbsa_ram #(
      .WIDTH (OFFSET_W),
      .DEPTH (BLOCK_COUNT_P)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign top_dec   = top_ff - TOP_W'(1);
   assign refuse    = (size_ff > MAX_SIZE) || (top_ff >= TOP_FULL);
   assign underflow = (top_ff == '0);
   assign top_init  = (32'(reserved_blocks) < 32'(BLOCK_COUNT_P)) ?
                      TOP_W'(reserved_blocks) : TOP_FULL;

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = top_ff[ADDR_W-1:0];
      ram_wdata = freed_ff;
      if (cmd.init_write) begin
         ram_we    = 1'b1;
         ram_addr  = cnt_ff;
         ram_wdata = acc_ff;
      end else if (cmd.commit && (cmd_ff == CMD_FREE) && !underflow) begin
         ram_we   = 1'b1;
         ram_addr = top_dec[ADDR_W-1:0];
      end
   end

   assign avail_bytes_in = BYTES_W'(TOP_FULL - top_ff) * BYTES_W'(BLOCK_BYTES);

   always_comb begin
      cmd_in    = cmd.capture ? req_command : cmd_ff;
      size_in   = cmd.capture ? req_request_size : size_ff;
      freed_in  = cmd.capture ? req_freed_offset : freed_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      top_in    = top_ff;
      valid_in  = valid_ff && !rsp_ready;
      status_in = status_ff;
      offset_in = offset_ff;
      free_in   = free_ff;
      total_in  = total_ff;
      if (cmd.init_clear) begin
         cnt_in = '0;
         acc_in = '0;
      end else if (cmd.init_write) begin
         cnt_in = cnt_ff + ADDR_W'(1);
         acc_in = acc_ff + STEP_BYTES;
      end
      if (cmd.init_finish) begin
         top_in = top_init;
      end
      if (cmd.commit) begin
         valid_in  = 1'b1;
         status_in = ST_OK;
         offset_in = '0;
         free_in   = '0;
         total_in  = '0;
         case (cmd_ff)
            CMD_ALLOC: begin
               if (refuse) begin
                  status_in = ST_REFUSED;
               end else begin
                  offset_in = ram_rdata;
                  top_in    = top_ff + TOP_W'(1);
               end
            end
            CMD_FREE: begin
               if (underflow) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  top_in = top_dec;
               end
            end
            CMD_INFO: begin
               free_in  = avail_bytes_ff;
               total_in = TOTAL_BYTES;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= TOP_FULL;
         valid_ff <= 1'b0;
      end else begin
         top_ff   <= top_in;
         valid_ff <= valid_in;
      end
      cmd_ff         <= cmd_in;
      size_ff        <= size_in;
      freed_ff       <= freed_in;
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      avail_bytes_ff <= avail_bytes_in;
      status_ff      <= status_in;
      offset_ff      <= offset_in;
      free_ff        <= free_in;
      total_ff       <= total_in;
   end

   assign stat.req_command = req_command;
   assign stat.init_last   = (cnt_ff == LAST_ADDR);
   assign stat.out_free    = !valid_ff || rsp_ready;

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_block_offset = offset_ff;
   assign rsp_free_bytes   = free_ff;
   assign rsp_total_bytes  = total_ff;

endmodule

@@ hdl/fbsa_controller.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator controller
// Sequences request capture, the init walk and the result commit.
// ----------------------------------------------------------------------------
module fbsa_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fbsa_pkg::fbsa_stat_type stat,
   output fbsa_pkg::fbsa_cmd_type  cmd
);
   import fbsa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INIT = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.req_command == CMD_INIT) begin
                  cmd.init_clear = 1'b1;
                  state_in       = S_INIT;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_INIT: begin
            cmd.init_write = 1'b1;
            if (stat.init_last) begin
               cmd.init_finish = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/fixed_block_free_stack_allocator.sv @@
// ----------------------------------------------------------------------------
// Fixed block free stack allocator
// Fixed-size block allocator kept as a stack of free block offsets in RAM.
// ----------------------------------------------------------------------------
// Allocate, free and info capture the request and read the stack RAM port in
// the idle state, then commit the result into the output register from exec.
// Init writes one stack entry a cycle through the single RAM port. A result
// waiting at the output stalls the commit.
// Reset empties the output and sets the stack pointer so nothing is free until init.
module fixed_block_free_stack_allocator #(
   parameter int BLOCK_COUNT_P = fbsa_pkg::BLOCK_COUNT_DEF,
   parameter int BLOCK_BYTES   = fbsa_pkg::BLOCK_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   fbsa_req_if.sink                        req_port,
   fbsa_rsp_if.source                      rsp_port,
   input  logic                            csr_wr_en,
   input  logic [fbsa_pkg::RESERVED_W-1:0] csr_wr_data
);
   import fbsa_pkg::*;

   fbsa_cmd_type              cmd;
   fbsa_stat_type             stat;
   logic [RESERVED_W-1:0]     reserved_ff, reserved_in;

   assign reserved_in = csr_wr_en ? csr_wr_data : reserved_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= RESERVED_RESET;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

   fbsa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbsa_datapath #(
      .BLOCK_COUNT_P (BLOCK_COUNT_P),
      .BLOCK_BYTES   (BLOCK_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_port.command),
      .req_request_size (req_port.request_size),
      .req_freed_offset (req_port.freed_offset),
      .reserved_blocks  (reserved_ff),
      .rsp_valid        (rsp_port.valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_status       (rsp_port.status),
      .rsp_block_offset (rsp_port.block_offset),
      .rsp_free_bytes   (rsp_port.free_bytes),
      .rsp_total_bytes  (rsp_port.total_bytes)
   );

endmodule

@@ hdl/fbsa_checker.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator checker
// Port-level assertions, bound to the allocator top level.
// ----------------------------------------------------------------------------
module fbsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [fbsa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [fbsa_pkg::OFFSET_W-1:0]   rsp_block_offset,
   input logic [fbsa_pkg::BYTES_W-1:0]    rsp_free_bytes
);
   import fbsa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on two consecutive cycles");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_REFUSED) ||
                    (rsp_status == ST_UNDERFLOW))
      else $error("unknown status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_block_offset == '0) && (rsp_free_bytes == '0))
      else $error("failed word carries payload");

endmodule

bind fixed_block_free_stack_allocator fbsa_checker u_fbsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_status       (rsp_port.status),
   .rsp_block_offset (rsp_port.block_offset),
   .rsp_free_bytes   (rsp_port.free_bytes)
);
